// ===== design/sfls_pkg.sv =====
// Shared constants and types for the symmetric FIR line smoother.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfls_pkg;

  // Build-time sizing
  localparam int MAX_RADIUS  = 5;
  localparam int MAX_LINE    = 4096;
  localparam int SAMPLE_BITS = 16;

  // Register file layout and fixed field widths
  localparam int WEIGHT_REGS = 6;
  localparam int RADIUS_W    = 3;
  localparam int LEN_W       = 13;
  localparam int WEIGHT_W    = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 30;
  localparam int POS_W       = 12;

  // Stream widths: tdata rounded up to whole bytes
  localparam int IN_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W = ((SUM_W + POS_W + 7) / 8) * 8;
  localparam int PAD_W = OUT_W - SUM_W - POS_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0    = CFG_IDX_W'(2);

  // Derived sizes
  localparam int TAP_COUNT = 2 * MAX_RADIUS + 1;
  // offsets beyond the last weight register carry zero weight
  localparam int NCELL     = ((MAX_RADIUS < WEIGHT_REGS - 1) ? MAX_RADIUS : WEIGHT_REGS - 1) + 1;
  localparam int PRE_W     = SAMPLE_BITS + 1;
  localparam int PROD_W    = PRE_W + WEIGHT_W;
  localparam int ACC_W     = SAMPLE_BITS + WEIGHT_W + $clog2(2 * WEIGHT_REGS);
  localparam int CNT_W     = $clog2(MAX_LINE);
  localparam int CMP_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
  localparam int LATENCY   = NCELL;

  typedef logic [PRE_W-1:0] pre_t;

  // Control of one accepted sample, from the position counter to the window
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [POS_W-1:0] pos;
  } item_ctrl_t;

  // Item travelling down the multiply-accumulate chain
  typedef struct packed {
    logic                   valid;
    logic                   last;
    logic [POS_W-1:0]       pos;
    logic [ACC_W-1:0]       acc;
    pre_t [NCELL-1:0]       pre;
  } mac_t;

endpackage

`default_nettype wire

// ===== design/sfls_window.sv =====
// Delay line of samples and the symmetric pre-add stage of the smoother.
// Depends on sfls_pkg.
`default_nettype none

module sfls_window (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            adv_i,
  input  wire logic                            accept_i,
  input  wire logic [sfls_pkg::SAMPLE_W-1:0]   sample_i,
  input  wire logic [sfls_pkg::RADIUS_W-1:0]   r_eff_i,
  input  wire sfls_pkg::item_ctrl_t            ctrl_i,
  output sfls_pkg::mac_t                       stage_o
);
  import sfls_pkg::*;

  logic [SAMPLE_BITS-1:0] dl_q [TAP_COUNT];
  logic [SAMPLE_BITS-1:0] dl_d [TAP_COUNT];
  pre_t [NCELL-1:0]       pre_d;
  mac_t                   stage_q;

  // Window as it stands once the new sample is in
  always_comb begin
    dl_d[0] = sample_i[SAMPLE_BITS-1:0];
    for (int i = 1; i < TAP_COUNT; i++) begin
      dl_d[i] = dl_q[i-1];
    end
  end

  // Fold the window around its centre tap
  always_comb begin
    pre_d = '0;
    for (int k = 0; k <= MAX_RADIUS; k++) begin
      if (int'(r_eff_i) == k) begin
        pre_d[0] = PRE_W'(dl_d[k]);
        for (int d = 1; d <= k && d < NCELL; d++) begin
          pre_d[d] = PRE_W'(dl_d[k-d]) + PRE_W'(dl_d[k+d]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        dl_q[i] <= '0;
      end
    end else if (accept_i) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        dl_q[i] <= dl_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q.valid <= accept_i & ctrl_i.emit;
      stage_q.last  <= ctrl_i.last;
      stage_q.pos   <= ctrl_i.pos;
      stage_q.acc   <= '0;
      stage_q.pre   <= pre_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== design/sfls_mac_cell.sv =====
// One cell of the multiply-accumulate chain: adds one weighted tap pair.
// Depends on sfls_pkg.
`default_nettype none

module sfls_mac_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire logic [sfls_pkg::WEIGHT_W-1:0]  weight_i,
  input  wire sfls_pkg::pre_t                 operand_i,
  input  wire sfls_pkg::mac_t                 cell_i,
  output sfls_pkg::mac_t                      cell_o
);
  import sfls_pkg::*;

  logic [PROD_W-1:0] product;
  logic [ACC_W-1:0]  acc_d;
  mac_t              cell_q;

  assign product = PROD_W'(operand_i) * PROD_W'(weight_i);
  assign acc_d   = cell_i.acc + ACC_W'(product);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (adv_i) begin
      cell_q.valid <= cell_i.valid;
      cell_q.last  <= cell_i.last;
      cell_q.pos   <= cell_i.pos;
      cell_q.acc   <= acc_d;
      cell_q.pre   <= cell_i.pre;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ===== design/symmetric_fir_line_smoother.sv =====
// Symmetric FIR line smoother: top level with config, position count and MAC chain.
// From input transfer to result: the pre-add register loads at the transfer, then six MAC cells.
// Throughput: one sample per cycle, the chain advancing every clock while no result waits.
// The whole chain holds while a result waits; samples within radius of a line end give none.
// Reset: rst_ni low clears valid bits, position count, delay line; radius 2, length 4096.
// Depends on sfls_pkg, sfls_window, sfls_mac_cell.
`default_nettype none

module symmetric_fir_line_smoother (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [sfls_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [sfls_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [sfls_pkg::IN_W-1:0]         s_axis_tdata,  // [15:0] sample
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [sfls_pkg::OUT_W-1:0]             m_axis_tdata,  // [29:0] smoothed_value,
                                                                // [41:30] position, zero pad
  output logic                                   m_axis_tlast   // last_of_line
);
  import sfls_pkg::*;

  // ------------------------------------------------------------------
  // Configuration registers; the port never pushes back
  // ------------------------------------------------------------------
  logic [RADIUS_W-1:0] radius_q;
  logic [LEN_W-1:0]    line_length_q;
  logic [WEIGHT_W-1:0] weight_q [WEIGHT_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= RADIUS_W'(2);
      line_length_q <= LEN_W'(4096);
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weight_q[i] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_RADIUS) begin
        radius_q <= cfg_data_i[RADIUS_W-1:0];
      end else if (cfg_index_i == REG_LINE_LENGTH) begin
        line_length_q <= cfg_data_i[LEN_W-1:0];
      end else begin
        for (int i = 0; i < WEIGHT_REGS; i++) begin
          if (int'(cfg_index_i) == int'(REG_WEIGHT_0) + i) begin
            weight_q[i] <= cfg_data_i[WEIGHT_W-1:0];
          end
        end
      end
    end
  end

  // Clamp radius and line length to what the hardware supports
  logic [RADIUS_W-1:0] r_eff;
  logic [LEN_W-1:0]    len_eff;

  always_comb begin
    if (int'(radius_q) > MAX_RADIUS) begin
      r_eff = RADIUS_W'(MAX_RADIUS);
    end else begin
      r_eff = radius_q;
    end
  end

  always_comb begin
    if (line_length_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (CMP_W'(line_length_q) > CMP_W'(MAX_LINE)) begin
      len_eff = LEN_W'(MAX_LINE);
    end else begin
      len_eff = line_length_q;
    end
  end

  // ------------------------------------------------------------------
  // Flow control: the whole chain moves together, and holds only while
  // the output register is full and not being taken
  // ------------------------------------------------------------------
  logic adv;
  logic accept;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // ------------------------------------------------------------------
  // Position counter: decide emit, last and centre index per sample
  // ------------------------------------------------------------------
  logic [CNT_W-1:0] count_q;
  logic [CMP_W-1:0] p_ext;
  logic [CMP_W-1:0] p_next;
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] two_r;
  logic             wrap;
  item_ctrl_t       ctrl;

  assign p_ext   = CMP_W'(count_q);
  assign p_next  = p_ext + CMP_W'(1);
  assign len_ext = CMP_W'(len_eff);
  assign two_r   = CMP_W'({r_eff, 1'b0});
  assign wrap    = p_next >= len_ext;

  assign ctrl.emit = (p_ext < len_ext) && (p_ext >= two_r);
  assign ctrl.last = p_next == len_ext;
  assign ctrl.pos  = POS_W'(count_q - CNT_W'(r_eff));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      // drop back to the line start once the line is done, or was shortened
      count_q <= wrap ? '0 : p_next[CNT_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Delay line and pre-add, then the MAC chain; the last cell is the
  // output register
  // ------------------------------------------------------------------
  mac_t chain [NCELL+1];

  sfls_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .accept_i (accept),
    .sample_i (s_axis_tdata[SAMPLE_W-1:0]),
    .r_eff_i  (r_eff),
    .ctrl_i   (ctrl),
    .stage_o  (chain[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    sfls_mac_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .weight_i  (weight_q[k]),
      .operand_i (chain[k].pre[k]),
      .cell_i    (chain[k]),
      .cell_o    (chain[k+1])
    );
  end

  // Accumulator is sized so the sum never exceeds the result field
  assign m_axis_tvalid = chain[NCELL].valid;
  assign m_axis_tlast  = chain[NCELL].last;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, chain[NCELL].pos, SUM_W'(chain[NCELL].acc)};

endmodule

`default_nettype wire

// ===== design/sfls_checker.sv =====
// Port-level checks of the symmetric FIR line smoother, bound to the top level.
// Depends on sfls_pkg and symmetric_fir_line_smoother.
`default_nettype none

module sfls_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [sfls_pkg::OUT_W-1:0]  m_axis_tdata,
  input wire logic                        m_axis_tlast
);
  import sfls_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // An empty output register never blocks the sample side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // A full, stalled output register stops the sample side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // Padding above the result fields stays zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_W-1:SUM_W+POS_W] == '0)
    else $error("result padding not zero");

endmodule

bind symmetric_fir_line_smoother sfls_checker u_sfls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
